// ===== design/lzwd_pkg.sv =====
// shared constants and types of the lzw code decoder
package lzwd_pkg;

    localparam int DICT_CODES     = 4096;
    localparam int MAX_STRING_LEN = 64;

    localparam int CODE_W = 15;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 2;
    localparam int CMP_W  = 16;
    localparam int ADDR_W = $clog2(DICT_CODES);
    localparam int NFC_W  = ADDR_W + 1;
    localparam int STK_W  = $clog2(MAX_STRING_LEN);

    localparam logic [CODE_W-1:0] CODE_END        = CODE_W'(256);
    localparam logic [NFC_W-1:0]  CODE_FIRST_FREE = NFC_W'(257);

    localparam logic [STAT_W-1:0] STAT_DATA = 2'd0;
    localparam logic [STAT_W-1:0] STAT_END  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERR  = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [BYTE_W-1:0] suffix;
        logic [LEN_W-1:0]  len;
    } t_dict_entry;

endpackage

// ===== design/lzwd_ram.sv =====
// generic simple dual port ram with registered read
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lzw_code_decoder_top.sv =====
// lzw code decoder: one code in, its dictionary string out as a run of bytes
//
// input channel: i_code_valid / o_code_ready carry one 15-bit lzw code per word.
// output channel: o_res_valid / i_res_ready carry one result word: a byte
// (status 0), an end-of-stream mark (status 1) or an error mark (status 2);
// o_last flags the final word caused by a code.
// one code is handled at a time; o_code_ready is high only while idle.
// a code runs through fetch and length check, one dictionary read per
// byte walking the prefix chain backward into a byte stack, the first
// byte appended again for a next-free code, the dictionary update, then
// one stack read per emitted byte.
// the single dictionary read port sets the walk rate, the stack read port
// the emit rate. end codes, codes outside the table and over-long strings
// each give a single mark word.
// end code 256 restarts the dictionary at 257; an error stops the stream
// until the next end code, and codes in a stopped stream give no words.
// a stalled receiver holds the output register and pauses emission.
// reset (i_rst_n low, synchronous) empties the dictionary and the history;
// the dictionary memory is not cleared, only entries written since the
// last end code or reset are ever used.
module lzw_code_decoder_top
    import lzwd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_code_valid,
    output logic                 o_code_ready,
    input  logic [CODE_W-1:0]    i_code,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [BYTE_W-1:0]    o_data_byte,
    output logic                 o_last,
    output logic [STAT_W-1:0]    o_status
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_LEN    = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_KW     = 3'd4;
    localparam logic [2:0] S_EPRE   = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;
    localparam logic [2:0] S_SINGLE = 3'd7;

    localparam logic [CMP_W-1:0] DICT_LIM = CMP_W'(DICT_CODES);
    localparam logic [LEN_W:0]   MAX_LEN  = (LEN_W+1)'(MAX_STRING_LEN);

    logic [2:0]          r_state, n_state;
    logic [CODE_W-1:0]   r_cur, n_cur;        // code being unwound
    logic [CODE_W-1:0]   r_code, n_code;      // code taken in
    logic                r_kw, n_kw;          // code is the next free one
    logic [LEN_W-1:0]    r_idx, n_idx;        // walk position
    logic [LEN_W-1:0]    r_n, n_n;            // string length
    logic [LEN_W-1:0]    r_k, n_k;            // emit position
    logic [BYTE_W-1:0]   r_first, n_first;    // first byte of the string
    logic [NFC_W-1:0]    r_nfc, n_nfc;
    logic [CODE_W-1:0]   r_prev, n_prev;
    logic                r_prev_valid, n_prev_valid;
    logic [LEN_W-1:0]    r_prev_len, n_prev_len;
    logic                r_stopped, n_stopped;
    logic [STAT_W-1:0]   r_stat, n_stat;
    logic                r_o_valid, n_o_valid;
    logic [BYTE_W-1:0]   r_o_data, n_o_data;
    logic                r_o_last, n_o_last;
    logic [STAT_W-1:0]   r_o_status, n_o_status;

    // memory ports
    logic                dict_we;
    logic [ADDR_W-1:0]   dict_waddr;
    t_dict_entry         dict_wdata;
    logic [ADDR_W-1:0]   dict_raddr;
    t_dict_entry         dict_rdata;
    logic                stk_we;
    logic [STK_W-1:0]    stk_waddr;
    logic [BYTE_W-1:0]   stk_wdata;
    logic [STK_W-1:0]    stk_raddr;
    logic [BYTE_W-1:0]   stk_rdata;

    logic                accept;
    logic                out_free;
    logic                room;
    logic [CMP_W-1:0]    code_ext;
    logic [CMP_W-1:0]    nfc_ext;
    logic [LEN_W-1:0]    len_l;
    logic [LEN_W:0]      n_total;
    logic [LEN_W-1:0]    idx_m1;
    logic [LEN_W-1:0]    n_m1;
    logic [LEN_W-1:0]    k_nx;

    assign accept    = i_code_valid && (r_state == S_IDLE);
    assign out_free  = !r_o_valid || i_res_ready;
    assign room      = CMP_W'(r_nfc) < DICT_LIM;
    assign code_ext  = CMP_W'(i_code);
    assign nfc_ext   = CMP_W'(r_nfc);
    assign len_l     = (r_cur[CODE_W-1:BYTE_W] == '0) ? LEN_W'(1) : dict_rdata.len;
    assign n_total   = (LEN_W+1)'(len_l) + (LEN_W+1)'(r_kw);
    assign idx_m1    = r_idx - LEN_W'(1);
    assign n_m1      = r_n - LEN_W'(1);
    assign k_nx      = r_k + LEN_W'(1);

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_code       = r_code;
        n_kw         = r_kw;
        n_idx        = r_idx;
        n_n          = r_n;
        n_k          = r_k;
        n_first      = r_first;
        n_nfc        = r_nfc;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_prev_len   = r_prev_len;
        n_stopped    = r_stopped;
        n_stat       = r_stat;
        n_o_valid    = r_o_valid && !i_res_ready;
        n_o_data     = r_o_data;
        n_o_last     = r_o_last;
        n_o_status   = r_o_status;

        dict_we         = 1'b0;
        dict_waddr      = r_nfc[ADDR_W-1:0];
        dict_wdata.prefix = r_prev;
        dict_wdata.suffix = r_first;
        dict_wdata.len  = r_prev_len + LEN_W'(1);
        dict_raddr      = r_cur[ADDR_W-1:0];
        stk_we          = 1'b0;
        stk_waddr       = idx_m1[STK_W-1:0];
        stk_wdata       = dict_rdata.suffix;
        stk_raddr       = r_k[STK_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_code = i_code;
                    n_kw   = 1'b0;
                    n_cur  = i_code;
                    if (i_code == CODE_END) begin
                        n_nfc        = CODE_FIRST_FREE;
                        n_prev_valid = 1'b0;
                        n_stopped    = 1'b0;
                        n_stat       = STAT_END;
                        n_state      = S_SINGLE;
                    end else if (r_stopped) begin
                        n_state = S_IDLE;
                    end else if (code_ext >= DICT_LIM) begin
                        n_stopped = 1'b1;
                        n_stat    = STAT_ERR;
                        n_state   = S_SINGLE;
                    end else if (i_code[CODE_W-1:BYTE_W] == '0 || code_ext < nfc_ext) begin
                        n_state = S_FETCH;
                    end else if (code_ext == nfc_ext && r_prev_valid && room) begin
                        // string is the previous one plus its own first byte
                        n_cur   = r_prev;
                        n_kw    = 1'b1;
                        n_state = S_FETCH;
                    end else begin
                        n_stopped = 1'b1;
                        n_stat    = STAT_ERR;
                        n_state   = S_SINGLE;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_LEN;
            end
            S_LEN: begin
                if (n_total > MAX_LEN) begin
                    n_stopped = 1'b1;
                    n_stat    = STAT_ERR;
                    n_state   = S_SINGLE;
                end else begin
                    n_n     = n_total[LEN_W-1:0];
                    n_idx   = len_l;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                stk_we = 1'b1;
                if (r_idx > LEN_W'(1)) begin
                    // suffix goes to the stack, follow the prefix
                    n_cur      = dict_rdata.prefix;
                    n_idx      = idx_m1;
                    dict_raddr = dict_rdata.prefix[ADDR_W-1:0];
                end else begin
                    stk_waddr = '0;
                    stk_wdata = r_cur[BYTE_W-1:0];
                    n_first   = r_cur[BYTE_W-1:0];
                    n_state   = r_kw ? S_KW : S_EPRE;
                end
            end
            S_KW: begin
                stk_we    = 1'b1;
                stk_waddr = n_m1[STK_W-1:0];
                stk_wdata = r_first;
                n_state   = S_EPRE;
            end
            S_EPRE: begin
                if (r_prev_valid && room) begin
                    dict_we = 1'b1;
                    n_nfc   = r_nfc + NFC_W'(1);
                end
                n_prev       = r_code;
                n_prev_valid = 1'b1;
                n_prev_len   = r_n;
                n_k          = '0;
                stk_raddr    = '0;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    stk_raddr  = k_nx[STK_W-1:0];
                    n_o_valid  = 1'b1;
                    n_o_data   = stk_rdata;
                    n_o_last   = (r_k == n_m1);
                    n_o_status = STAT_DATA;
                    n_k        = k_nx;
                    if (r_k == n_m1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_data   = '0;
                    n_o_last   = 1'b1;
                    n_o_status = r_stat;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_nfc        <= CODE_FIRST_FREE;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_stopped    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_nfc        <= n_nfc;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_stopped    <= n_stopped;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_code     <= n_code;
        r_kw       <= n_kw;
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_k        <= n_k;
        r_first    <= n_first;
        r_prev_len <= n_prev_len;
        r_stat     <= n_stat;
        r_o_data   <= n_o_data;
        r_o_last   <= n_o_last;
        r_o_status <= n_o_status;
    end

    // prefix, suffix and length of each dictionary entry
    lzwd_ram #(
        .WIDTH ($bits(t_dict_entry)),
        .DEPTH (DICT_CODES)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (dict_we),
        .i_waddr (dict_waddr),
        .i_wdata (dict_wdata),
        .i_raddr (dict_raddr),
        .o_rdata (dict_rdata)
    );

    // bytes of the current string in forward order
    lzwd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_STRING_LEN)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_code_ready = (r_state == S_IDLE);
    assign o_res_valid  = r_o_valid;
    assign o_data_byte  = r_o_data;
    assign o_last       = r_o_last;
    assign o_status     = r_o_status;

    // dictionary pointer never runs past the table
    a_nfc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_nfc) <= DICT_LIM)
        else $error("next free code past table");

    // the walk never reaches a position below the first byte
    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx != '0))
        else $error("walk index underflow");

    // emitted strings respect the length limit
    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ((LEN_W+1)'(r_n) <= MAX_LEN && r_n != '0))
        else $error("emit length out of range");

    // an end code always leads to an end-of-stream word and a fresh table
    a_end_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_code == CODE_END) |=>
            (r_state == S_SINGLE && r_stat == STAT_END && r_nfc == CODE_FIRST_FREE
             && !r_stopped))
        else $error("end code mishandled");

    // a stopped stream never starts decoding
    a_stopped_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_stopped && i_code != CODE_END) |=> (r_state == S_IDLE))
        else $error("stopped stream decoded a code");

endmodule

// ===== dv/lzw_code_decoder_top_tb.sv =====
// self-checking testbench of the lzw code decoder: random and directed codes, in-order word check (byte, last, status)
`timescale 1ns / 100ps

module lzw_code_decoder_top_tb;
    import lzwd_pkg::*;

    // two copies of the decoder state: one steers stimulus generation,
    // the other tracks the codes the block actually accepted
    localparam int STIM_VIEW  = 0;
    localparam int CHK_VIEW   = 1;
    localparam int BYTE_CODES = 256;

    // receiver hold-off: long enough for the block to fill and stall its input
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [STAT_W-1:0] status;
    } t_word;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              code_valid = 1'b0;
    logic [CODE_W-1:0] code       = '0;
    logic              res_ready  = 1'b0;
    logic              code_ready;
    logic              res_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic [STAT_W-1:0] status;

    // codes waiting to be offered, and decoded words waiting to come out
    logic [CODE_W-1:0] pending_codes[$];
    t_word             expected_words[$];

    // decoder state, per view
    logic [CODE_W-1:0] dict_prefix [2][DICT_CODES];
    logic [BYTE_W-1:0] dict_suffix [2][DICT_CODES];
    logic [LEN_W-1:0]  dict_len    [2][DICT_CODES];
    int unsigned       free_code   [2];
    logic [CODE_W-1:0] prev_code   [2];
    bit                have_prev   [2];
    bit                halted      [2];

    int  codes_taken = 0;
    int  live_codes  = 0;
    int  fail_count  = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    wire calm        = (codes_taken >= 40) && (codes_taken < 100);

    lzw_code_decoder_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_code_valid (code_valid),
        .o_code_ready (code_ready),
        .i_code       (code),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_data_byte  (data_byte),
        .o_last       (last),
        .o_status     (status)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // decoder prediction
    // ------------------------------------------------------------------

    function automatic void clear_history(int v);
        free_code[v] = 32'(CODE_FIRST_FREE);
        prev_code[v] = '0;
        have_prev[v] = 1'b0;
        halted[v]    = 1'b0;
    endfunction

    // string length of a code; zero means it names nothing
    function automatic int unsigned str_len(int v, int unsigned c);
        if (c < BYTE_CODES) return 1;
        if (c < DICT_CODES) return dict_len[v][c];
        return 0;
    endfunction

    // decodes one code on view v; queues the expected words when record is set
    function automatic void decode_code(int v, logic [CODE_W-1:0] c, bit record);
        int unsigned n, m, i, cur, e;
        bit room, kwk;
        logic [BYTE_W-1:0] stk [MAX_STRING_LEN];
        room = free_code[v] < DICT_CODES;
        kwk  = 1'b0;
        n    = 0;
        cur  = 32'(c);
        if (c == CODE_END) begin
            clear_history(v);
            if (record) expected_words.push_back('{'0, 1'b1, STAT_END});
            return;
        end
        if (halted[v]) return;
        // codes at or above the table size fall through with n = 0
        if (c < DICT_CODES && (c < BYTE_CODES || c < free_code[v])) begin
            n = str_len(v, 32'(c));
        end else if (c < DICT_CODES && c == free_code[v] && have_prev[v] && room) begin
            // code not yet in the table: previous string plus its own first byte
            kwk = 1'b1;
            cur = 32'(prev_code[v]);
            n   = str_len(v, cur) + 1;
        end
        if (n == 0 || n > MAX_STRING_LEN || (kwk && n == 1)) begin
            halted[v] = 1'b1;
            if (record) expected_words.push_back('{'0, 1'b1, STAT_ERR});
            return;
        end
        // walk the prefix chain backward
        m = kwk ? n - 1 : n;
        i = m;
        while (i > 1) begin
            i--;
            if (cur >= BYTE_CODES) begin
                stk[i] = dict_suffix[v][cur];
                cur    = 32'(dict_prefix[v][cur]);
            end else begin
                stk[i] = '0;
            end
        end
        stk[0] = BYTE_W'(cur);
        if (kwk) stk[n-1] = stk[0];
        if (have_prev[v] && room) begin
            e = free_code[v];
            dict_prefix[v][e] = prev_code[v];
            dict_suffix[v][e] = stk[0];
            dict_len[v][e]    = LEN_W'(str_len(v, 32'(prev_code[v])) + 1);
            free_code[v]      = e + 1;
        end
        prev_code[v] = c;
        have_prev[v] = 1'b1;
        if (record) begin
            for (int k = 0; k < n; k++) begin
                expected_words.push_back('{stk[k], k == n - 1, STAT_DATA});
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers, all working on the stimulus view
    // ------------------------------------------------------------------

    function automatic void send_code(logic [CODE_W-1:0] c);
        // codes in a stopped stream are ignored and do not count
        if (c == CODE_END || !halted[STIM_VIEW]) live_codes++;
        pending_codes.push_back(c);
        decode_code(STIM_VIEW, c, 1'b0);
    endfunction

    // a code that decodes cleanly: a byte or a table entry of legal length
    function automatic logic [CODE_W-1:0] pick_known(int dict_pct);
        int unsigned c;
        if (free_code[STIM_VIEW] > CODE_FIRST_FREE && $urandom_range(99) < dict_pct) begin
            for (int t = 0; t < 8; t++) begin
                c = $urandom_range(free_code[STIM_VIEW] - 1, CODE_FIRST_FREE);
                if (str_len(STIM_VIEW, c) <= MAX_STRING_LEN) return CODE_W'(c);
            end
        end
        return CODE_W'($urandom_range(BYTE_CODES - 1, 0));
    endfunction

    // fresh stream of one byte followed by repeated next-free codes,
    // each one byte longer than the last
    function automatic void run_chain(int steps);
        send_code(CODE_END);
        send_code(CODE_W'($urandom_range(BYTE_CODES - 1, 0)));
        for (int k = 0; k < steps && !halted[STIM_VIEW]; k++) begin
            send_code(CODE_W'(free_code[STIM_VIEW]));
        end
    endfunction

    // ------------------------------------------------------------------
    // reset
    // ------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // driver: offers pending codes, predicts each accepted one
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n) begin
            code_valid <= 1'b0;
        end else begin
            if (code_valid && code_ready) begin
                decode_code(CHK_VIEW, code, 1'b1);
                codes_taken <= codes_taken + 1;
            end
            // payload only changes once the current word is taken
            if (!code_valid || code_ready) begin
                if (pending_codes.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
                    code_valid <= 1'b1;
                    code       <= pending_codes.pop_front();
                end else begin
                    code_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, one long hold-off, calm window
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end else if (!hold_done && codes_taken >= 12) begin
            // sender keeps offering meanwhile, so the block backs up
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            res_ready <= 1'b0;
        end else begin
            res_ready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // ------------------------------------------------------------------
    // monitor: every accepted word against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        t_word want;
        if (rst_n && res_valid && res_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: data_byte %0h last %0b status %0d",
                       data_byte, last, status);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (data_byte !== want.data) begin
                    $error("data_byte mismatch: expected %0h, got %0h", want.data, data_byte);
                    fail_count++;
                end
                if (last !== want.last) begin
                    $error("last mismatch: expected %0b, got %0b", want.last, last);
                    fail_count++;
                end
                if (status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------

    initial begin
        int r;
        int unsigned fc;
        clear_history(STIM_VIEW);
        clear_history(CHK_VIEW);

        // directed: undefined code with no history, ignored codes in a
        // stopped stream, end while stopped, byte extremes, table entry,
        // next-free code, code above next-free, out-of-table codes
        send_code(CODE_W'(257));
        send_code(CODE_W'(0));
        send_code(CODE_END);
        send_code(CODE_W'(0));
        send_code(CODE_W'(255));
        send_code(CODE_W'(257));
        send_code(CODE_W'(259));
        send_code(CODE_W'(259));
        send_code(CODE_W'(300));
        send_code(CODE_W'(5));
        send_code(CODE_END);
        send_code(CODE_W'(32767));
        send_code(CODE_END);
        send_code(CODE_W'(128));
        send_code(CODE_W'(DICT_CODES));
        send_code(CODE_END);
        send_code(CODE_W'(DICT_CODES - 1));
        send_code(CODE_END);
        send_code(CODE_W'(85));
        send_code(CODE_W'(10922));
        send_code(CODE_END);

        // longest legal string, then an over-long stored entry
        live_codes = 0;
        run_chain(MAX_STRING_LEN - 1);
        send_code(CODE_W'($urandom_range(BYTE_CODES - 1, 0)));
        send_code(CODE_W'(free_code[STIM_VIEW] - 1));

        // random part: mostly well-formed streams, some noise and breaks
        while (live_codes < 95) begin
            r = $urandom_range(99);
            if (halted[STIM_VIEW] && r < 70) send_code(CODE_END);
            if (r < 55) begin
                repeat ($urandom_range(12, 4)) begin
                    fc = free_code[STIM_VIEW];
                    if ($urandom_range(99) < 20 && have_prev[STIM_VIEW] && fc < DICT_CODES
                        && str_len(STIM_VIEW, 32'(prev_code[STIM_VIEW])) < MAX_STRING_LEN)
                    begin
                        send_code(CODE_W'(fc));
                    end else begin
                        send_code(pick_known(70));
                    end
                end
            end else if (r < 65) begin
                send_code(CODE_END);
            end else if (r < 80) begin
                case ($urandom_range(2))
                    0: send_code(CODE_W'($urandom_range(32767, 0)));
                    1: send_code(CODE_W'(free_code[STIM_VIEW] + $urandom_range(40, 1)));
                    default: begin
                        send_code(CODE_END);
                        send_code(CODE_W'(free_code[STIM_VIEW]));
                    end
                endcase
            end else if (r < 92) begin
                repeat ($urandom_range(4, 1)) send_code(pick_known(50));
                send_code(CODE_W'($urandom_range(32767, 0)));
                send_code(pick_known(50));
            end else begin
                run_chain($urandom_range(16, 4));
            end
        end

        // out-of-table code, then a fresh stream
        send_code(CODE_W'(DICT_CODES));
        send_code(CODE_END);
        send_code(CODE_W'($urandom_range(BYTE_CODES - 1, 0)));

        // drain: everything offered, everything decoded, then a quiet tail
        while (pending_codes.size() != 0 || code_valid) @(negedge clk);
        while (expected_words.size() != 0) @(negedge clk);
        repeat (4 * MAX_STRING_LEN + 50) @(negedge clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lzwd_pkg.sv
design/lzwd_ram.sv
design/lzw_code_decoder_top.sv
dv/lzw_code_decoder_top_tb.sv
